/* rtl/sgle_pkg.sv */
// Shared types and constants of the systolic GEMM latency estimator.
package sgle_pkg;

	localparam int unsigned TILE_DIV_BITS = 17;
	localparam int unsigned LAT_DIV_BITS  = 67;
	localparam int unsigned DIV_CNT_W     = 7;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ZERO_DIM = 2'd1;
	localparam logic [1:0] STATUS_DW_N     = 2'd2;

	typedef enum logic [2:0] {
		REG_ARRAY_ROWS  = 3'd0,
		REG_ARRAY_COLS  = 3'd1,
		REG_WEIGHT_LOAD = 3'd2,
		REG_DW_OVERHEAD = 3'd3,
		REG_UTILIZATION = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_M,
		ST_DIV_N,
		ST_MUL_MK,
		ST_MUL_MKN,
		ST_MUL_TT,
		ST_MUL_RAW,
		ST_SCALE,
		ST_DIV_LAT,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [15:0] m_dim;
		logic [15:0] k_dim;
		logic [15:0] n_dim;
		logic        is_depthwise;
	} cmd_t;

	typedef struct packed {
		logic [47:0] latency_cycles;
		logic        latency_saturated;
		logic [47:0] mac_count;
		logic [1:0]  status;
		logic [31:0] dense_total;
		logic [31:0] depthwise_total;
		logic [63:0] mac_total;
	} rsp_t;

endpackage

/* rtl/systolic_gemm_latency_estimator.sv */
// Top level of the systolic GEMM latency estimator.
//
// A command item (M, K, N and a depthwise flag) enters on the cmd channel and
// one result item leaves on the rsp channel. Both channels move an item at a
// rising edge where valid is high and stall is low. Array size, per-tile weight
// load cost, depthwise overhead and the Q1.16 utilization factor are written
// through the APB-style register port; the user must do so only while the
// block is idle, as the block itself does not enforce it. A valid command runs
// two 17-step tile divisions, four products on one shared multiplier, one
// 67-step division for the utilization scaling and bookkeeping steps. All
// divisions use the single shared restoring divider, one quotient bit per cycle.
// A command with an error status goes straight to its result. cmd_stall is
// high while a command is being worked on, so one command is in flight at a
// time and the next one is accepted only once the result has left the last step.
// The result sits in an output register; a stalled result holds there while
// the next command is already accepted and worked on. A finished command waits
// in its last step until that register is free.
// Reset clears the running totals, loads the register defaults (16 x 16
// array, no extra costs, utilization 1.0) and empties the output register.
module systolic_gemm_latency_estimator
	import sgle_pkg::*;
#(
	parameter int unsigned DIM_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [10:0] array_rows_q;
	logic [10:0] array_cols_q;
	logic [15:0] weight_load_q;
	logic [15:0] dw_overhead_q;
	logic [16:0] util_q;

	logic [10:0] rows_eff;
	logic [10:0] cols_eff;
	logic [16:0] util_eff;

	state_t state_q, state_d;

	logic [DIM_WIDTH-1:0] m_in, k_in, n_in;
	logic [DIM_WIDTH-1:0] m_q, k_q, n_q, tm_q, tn_q;
	logic                 dw_q;
	logic [17:0]          per_tile_q;
	logic [1:0]           status_q;
	logic [1:0]           status_in;
	logic [47:0]          mac_q;
	logic [47:0]          lat_q;
	logic                 sat_q;

	logic [31:0] dense_cnt_q;
	logic [31:0] dw_cnt_q;
	logic [63:0] mac_acc_q;
	logic [64:0] mac_sum;

	logic [31:0] mul_a;
	logic [17:0] mul_b;
	logic [49:0] mul_p;
	logic [49:0] prod_q;
	logic [49:0] raw_total;

	logic                    div_load;
	logic [LAT_DIV_BITS-1:0] div_num_ld;
	logic [16:0]             div_den_ld;
	logic [DIV_CNT_W-1:0]    div_cnt_ld;
	logic [LAT_DIV_BITS-1:0] div_num_q;
	logic [16:0]             div_den_q;
	logic [16:0]             div_rem_q;
	logic [LAT_DIV_BITS-1:0] div_quo_q;
	logic [DIV_CNT_W-1:0]    div_cnt_q;
	logic [17:0]             div_trial;
	logic                    div_ge;
	logic [17:0]             div_diff;
	logic                    div_busy;

	logic accept;
	logic rsp_load;
	logic cfg_write;
	rsp_t rsp_q;
	logic rsp_valid_q;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			array_rows_q  <= 11'd16;
			array_cols_q  <= 11'd16;
			weight_load_q <= 16'd0;
			dw_overhead_q <= 16'd0;
			util_q        <= 17'h10000;
		end else if (cfg_write) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_ARRAY_ROWS:  array_rows_q  <= pwdata[10:0];
				REG_ARRAY_COLS:  array_cols_q  <= pwdata[10:0];
				REG_WEIGHT_LOAD: weight_load_q <= pwdata[15:0];
				REG_DW_OVERHEAD: dw_overhead_q <= pwdata[15:0];
				REG_UTILIZATION: util_q        <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_ARRAY_ROWS:  prdata = 32'(array_rows_q);
			REG_ARRAY_COLS:  prdata = 32'(array_cols_q);
			REG_WEIGHT_LOAD: prdata = 32'(weight_load_q);
			REG_DW_OVERHEAD: prdata = 32'(dw_overhead_q);
			REG_UTILIZATION: prdata = 32'(util_q);
			default:         prdata = 32'd0;
		endcase
	end

	assign rows_eff = (array_rows_q == 11'd0) ? 11'd1 : array_rows_q;
	assign cols_eff = (array_cols_q == 11'd0) ? 11'd1 : array_cols_q;
	assign util_eff = (util_q == 17'd0) ? 17'd1 : util_q;

	assign m_in = cmd.m_dim[DIM_WIDTH-1:0];
	assign k_in = cmd.k_dim[DIM_WIDTH-1:0];
	assign n_in = cmd.n_dim[DIM_WIDTH-1:0];

	always_comb begin
		if (m_in == '0 || k_in == '0 || n_in == '0) begin
			status_in = STATUS_ZERO_DIM;
		end else if (cmd.is_depthwise && n_in != DIM_WIDTH'(1)) begin
			status_in = STATUS_DW_N;
		end else begin
			status_in = STATUS_OK;
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid & ~cmd_stall;
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	assign div_busy  = (div_cnt_q != '0);

	assign raw_total = prod_q + (dw_q ? 50'(dw_overhead_q) : 50'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		div_load   = 1'b0;
		div_num_ld = '0;
		div_den_ld = '0;
		div_cnt_ld = '0;
		mul_a      = '0;
		mul_b      = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (status_in == STATUS_OK) begin
						div_load   = 1'b1;
						div_num_ld = {17'(m_in) + 17'(rows_eff) - 17'd1,
							{(LAT_DIV_BITS - TILE_DIV_BITS){1'b0}}};
						div_den_ld = 17'(rows_eff);
						div_cnt_ld = DIV_CNT_W'(TILE_DIV_BITS);
						state_d    = ST_DIV_M;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DIV_M: begin
				if (!div_busy) begin
					div_load   = 1'b1;
					div_num_ld = {17'(n_q) + 17'(cols_eff) - 17'd1,
						{(LAT_DIV_BITS - TILE_DIV_BITS){1'b0}}};
					div_den_ld = 17'(cols_eff);
					div_cnt_ld = DIV_CNT_W'(TILE_DIV_BITS);
					state_d    = ST_DIV_N;
				end
			end
			ST_DIV_N: begin
				if (!div_busy) begin
					state_d = ST_MUL_MK;
				end
			end
			ST_MUL_MK: begin
				mul_a   = 32'(m_q);
				mul_b   = 18'(k_q);
				state_d = ST_MUL_MKN;
			end
			ST_MUL_MKN: begin
				mul_a   = prod_q[31:0];
				mul_b   = 18'(n_q);
				state_d = ST_MUL_TT;
			end
			ST_MUL_TT: begin
				mul_a   = 32'(tm_q);
				mul_b   = 18'(tn_q);
				state_d = ST_MUL_RAW;
			end
			ST_MUL_RAW: begin
				mul_a   = prod_q[31:0];
				mul_b   = per_tile_q;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				div_load   = 1'b1;
				div_num_ld = LAT_DIV_BITS'({raw_total, 16'h0}) +
					LAT_DIV_BITS'(util_eff - 17'd1);
				div_den_ld = util_eff;
				div_cnt_ld = DIV_CNT_W'(LAT_DIV_BITS);
				state_d    = ST_DIV_LAT;
			end
			ST_DIV_LAT: begin
				if (!div_busy) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign div_trial = {div_rem_q, div_num_q[LAT_DIV_BITS-1]};
	assign div_ge    = (div_trial >= {1'b0, div_den_q});
	assign div_diff  = div_trial - {1'b0, div_den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (div_load) begin
			div_cnt_q <= div_cnt_ld;
		end else if (div_busy) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			div_num_q <= div_num_ld;
			div_den_q <= div_den_ld;
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (div_busy) begin
			div_num_q <= {div_num_q[LAT_DIV_BITS-2:0], 1'b0};
			div_rem_q <= div_ge ? div_diff[16:0] : div_trial[16:0];
			div_quo_q <= {div_quo_q[LAT_DIV_BITS-2:0], div_ge};
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					m_q        <= m_in;
					k_q        <= k_in;
					n_q        <= n_in;
					dw_q       <= cmd.is_depthwise;
					status_q   <= status_in;
					per_tile_q <= 18'(weight_load_q) + 18'(k_in) + 18'(rows_eff) +
						18'(cols_eff) - 18'd1;
					mac_q      <= '0;
					lat_q      <= '0;
					sat_q      <= 1'b0;
				end
			end
			ST_DIV_M: begin
				if (!div_busy) begin
					tm_q <= div_quo_q[DIM_WIDTH-1:0];
				end
			end
			ST_DIV_N: begin
				if (!div_busy) begin
					tn_q <= div_quo_q[DIM_WIDTH-1:0];
				end
			end
			ST_MUL_MK, ST_MUL_MKN, ST_MUL_RAW: begin
				prod_q <= mul_p;
			end
			ST_MUL_TT: begin
				mac_q  <= prod_q[47:0];
				prod_q <= mul_p;
			end
			ST_DIV_LAT: begin
				if (!div_busy) begin
					sat_q <= |div_quo_q[LAT_DIV_BITS-1:48];
					lat_q <= (|div_quo_q[LAT_DIV_BITS-1:48]) ? '1 : div_quo_q[47:0];
				end
			end
			default: ;
		endcase
	end

	assign mac_sum = {1'b0, mac_acc_q} + 65'(mac_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dense_cnt_q <= '0;
			dw_cnt_q    <= '0;
			mac_acc_q   <= '0;
		end else if (state_q == ST_UPDATE) begin
			if (dw_q) begin
				dw_cnt_q <= dw_cnt_q + 32'd1;
			end else begin
				dense_cnt_q <= dense_cnt_q + 32'd1;
			end
			mac_acc_q <= mac_sum[64] ? '1 : mac_sum[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.latency_cycles    <= lat_q;
			rsp_q.latency_saturated <= sat_q;
			rsp_q.mac_count         <= mac_q;
			rsp_q.status            <= status_q;
			rsp_q.dense_total       <= dense_cnt_q;
			rsp_q.depthwise_total   <= dw_cnt_q;
			rsp_q.mac_total         <= mac_acc_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/sgle_checker.sv */
// Port-level checks of the systolic GEMM latency estimator and their binding.
module sgle_checker
	import sgle_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled result item changed or dropped.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("Block took no time on an accepted item.");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STATUS_OK |->
		rsp.latency_cycles == '0 && rsp.mac_count == '0 && !rsp.latency_saturated)
		else $error("Error result item carries nonzero latency or MAC count.");

	a_sat_clips: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.latency_saturated |-> rsp.latency_cycles == '1)
		else $error("Saturated latency is not at its maximum.");

endmodule

bind systolic_gemm_latency_estimator sgle_checker u_sgle_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

/* tb/tb_top.sv */
// Self-checking testbench for the systolic GEMM latency estimator.
module tb_top
	import sgle_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] LAT_LIMIT = 64'hFFFF_FFFF_FFFF;
	localparam int WATCHDOG_CYCLES = 2000;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	cmd_t        cmd;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic [10:0] rows_cfg;
	logic [10:0] cols_cfg;
	logic [15:0] weight_cfg;
	logic [15:0] dw_cfg;
	logic [16:0] util_cfg;
	logic [31:0] dense_count;
	logic [31:0] dw_count;
	logic [63:0] mac_sum;

	rsp_t pending_rsp[$];
	rsp_t got_rsp;
	rsp_t want_rsp;
	int   errors;
	int   idle_cycles;
	bit   quiet;

	systolic_gemm_latency_estimator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic rsp_t estimate_latency(cmd_t c);
		logic [63:0]  m, k, n, rows, cols, util, tiles_m, tiles_n, per_tile, raw, macs;
		logic [127:0] scaled;
		rsp_t r;
		r = '0;
		m = {48'd0, c.m_dim};
		k = {48'd0, c.k_dim};
		n = {48'd0, c.n_dim};
		rows = (rows_cfg == 0) ? 64'd1 : {53'd0, rows_cfg};
		cols = (cols_cfg == 0) ? 64'd1 : {53'd0, cols_cfg};
		util = (util_cfg == 0) ? 64'd1 : {47'd0, util_cfg};
		if (m == 0 || k == 0 || n == 0) begin
			r.status = STATUS_ZERO_DIM;
		end else if (c.is_depthwise && n != 1) begin
			r.status = STATUS_DW_N;
		end else begin
			r.status = STATUS_OK;
			tiles_m = (m + rows - 1) / rows;
			tiles_n = (n + cols - 1) / cols;
			per_tile = {48'd0, weight_cfg} + k + rows + cols - 1;
			raw = tiles_m * tiles_n * per_tile;
			if (c.is_depthwise)
				raw = raw + {48'd0, dw_cfg};
			scaled = (({64'd0, raw} << 16) + {64'd0, util} - 1) / {64'd0, util};
			if (scaled > {64'd0, LAT_LIMIT}) begin
				r.latency_cycles = LAT_LIMIT[47:0];
				r.latency_saturated = 1'b1;
			end else begin
				r.latency_cycles = scaled[47:0];
			end
			macs = m * k * n;
			r.mac_count = macs[47:0];
			if (c.is_depthwise)
				dw_count = dw_count + 1;
			else
				dense_count = dense_count + 1;
			if (mac_sum > ~64'd0 - macs)
				mac_sum = ~64'd0;
			else
				mac_sum = mac_sum + macs;
		end
		r.dense_total = dense_count;
		r.depthwise_total = dw_count;
		r.mac_total = mac_sum;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (errors < 40)
			$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				pending_rsp.push_back(estimate_latency(cmd));
			if (rsp_valid && !rsp_stall) begin
				got_rsp = rsp;
				if (pending_rsp.size() == 0) begin
					report_mismatch("unexpected item", 64'd1, 64'd0);
				end else begin
					want_rsp = pending_rsp.pop_front();
					if (got_rsp.latency_cycles !== want_rsp.latency_cycles)
						report_mismatch("latency_cycles", 64'(got_rsp.latency_cycles),
							64'(want_rsp.latency_cycles));
					if (got_rsp.latency_saturated !== want_rsp.latency_saturated)
						report_mismatch("latency_saturated",
							64'(got_rsp.latency_saturated),
							64'(want_rsp.latency_saturated));
					if (got_rsp.mac_count !== want_rsp.mac_count)
						report_mismatch("mac_count", 64'(got_rsp.mac_count),
							64'(want_rsp.mac_count));
					if (got_rsp.status !== want_rsp.status)
						report_mismatch("status", 64'(got_rsp.status), 64'(want_rsp.status));
					if (got_rsp.dense_total !== want_rsp.dense_total)
						report_mismatch("dense_total", 64'(got_rsp.dense_total),
							64'(want_rsp.dense_total));
					if (got_rsp.depthwise_total !== want_rsp.depthwise_total)
						report_mismatch("depthwise_total", 64'(got_rsp.depthwise_total),
							64'(want_rsp.depthwise_total));
					if (got_rsp.mac_total !== want_rsp.mac_total)
						report_mismatch("mac_total", got_rsp.mac_total, want_rsp.mac_total);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || psel || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("** systolic_gemm_latency_estimator: FAILED **");
			$finish;
		end
	end

	initial begin
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic cfg_write(reg_idx_t idx, logic [31:0] value);
		logic [31:0] masked;
		case (idx)
			REG_ARRAY_ROWS:  masked = value & 32'h7FF;
			REG_ARRAY_COLS:  masked = value & 32'h7FF;
			REG_WEIGHT_LOAD: masked = value & 32'hFFFF;
			REG_DW_OVERHEAD: masked = value & 32'hFFFF;
			REG_UTILIZATION: masked = value & 32'h1FFFF;
			default:         masked = '0;
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== masked)
			report_mismatch("register read", 64'(prdata), 64'(masked));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ARRAY_ROWS:  rows_cfg = masked[10:0];
			REG_ARRAY_COLS:  cols_cfg = masked[10:0];
			REG_WEIGHT_LOAD: weight_cfg = masked[15:0];
			REG_DW_OVERHEAD: dw_cfg = masked[15:0];
			REG_UTILIZATION: util_cfg = masked[16:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic cfg_all(logic [31:0] rows, logic [31:0] cols, logic [31:0] weight,
		logic [31:0] overhead, logic [31:0] util);
		cfg_write(REG_ARRAY_ROWS, rows);
		cfg_write(REG_ARRAY_COLS, cols);
		cfg_write(REG_WEIGHT_LOAD, weight);
		cfg_write(REG_DW_OVERHEAD, overhead);
		cfg_write(REG_UTILIZATION, util);
	endtask

	task automatic send_cmd(cmd_t c);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [15:0] random_dim();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 16'($urandom_range(1, 64));
			5, 6, 7:       return 16'($urandom_range(1, 4096));
			8:             return 16'($urandom_range(1, 65535));
			default:       return $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
		endcase
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		c.m_dim = random_dim();
		c.k_dim = random_dim();
		c.n_dim = random_dim();
		c.is_depthwise = ($urandom_range(0, 9) < 3);
		if (c.is_depthwise && $urandom_range(0, 9) != 0)
			c.n_dim = 16'd1;
		if ($urandom_range(0, 19) == 0) begin
			case ($urandom_range(0, 2))
				0:       c.m_dim = '0;
				1:       c.k_dim = '0;
				default: c.n_dim = '0;
			endcase
		end
		return c;
	endfunction

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2 || $urandom_range(0, 149) == 0)
				wait_drain();
			send_cmd(random_cmd());
		end
		wait_drain();
	endtask

	task automatic send_corner_set();
		send_cmd('{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0});
		send_cmd('{16'hFFFF, 16'hFFFF, 16'd1, 1'b1});
		send_cmd('{16'd1, 16'd1, 16'd1, 1'b0});
		send_cmd('{16'd1, 16'd1, 16'd1, 1'b1});
		send_cmd('{16'd1000, 16'd300, 16'd1000, 1'b0});
		send_cmd('{16'd2047, 16'd7, 16'd1025, 1'b0});
	endtask

	task automatic test_directed();
		send_cmd('{16'd0, 16'd1, 16'd1, 1'b0});
		send_cmd('{16'd1, 16'd0, 16'd1, 1'b0});
		send_cmd('{16'd1, 16'd1, 16'd0, 1'b0});
		send_cmd('{16'd0, 16'd0, 16'd0, 1'b1});
		send_cmd('{16'd5, 16'd5, 16'd0, 1'b1});
		send_cmd('{16'd5, 16'd5, 16'd2, 1'b1});
		send_cmd('{16'd5, 16'd5, 16'hFFFF, 1'b1});
		send_cmd('{16'hFFFF, 16'hFFFF, 16'd1, 1'b1});
		send_cmd('{16'd1, 16'd1, 16'd1, 1'b1});
		send_cmd('{16'd1, 16'd1, 16'd1, 1'b0});
		send_cmd('{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0});
		send_cmd('{16'd16, 16'd16, 16'd16, 1'b0});
		send_cmd('{16'd17, 16'd1, 16'd17, 1'b0});
		send_cmd('{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0});
		send_cmd('{16'h5555, 16'hAAAA, 16'h5555, 1'b0});
		send_cmd('{16'h5555, 16'hAAAA, 16'd1, 1'b1});
		wait_drain();
	endtask

	task automatic test_config_corners();
		// Zero sizes and zero utilization count as one; upper bus bits are ignored.
		cfg_all(32'hFFFF_F800, 32'hFFFF_F800, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFE_0000);
		send_corner_set();
		run_random(20);
		cfg_all(32'd2047, 32'd2047, 32'd0, 32'd0, 32'h1FFFF);
		send_corner_set();
		run_random(20);
		cfg_all(32'd1024, 32'd1024, 32'd65535, 32'd65535, 32'd1);
		send_corner_set();
		run_random(20);
		cfg_all(32'd1, 32'd1, 32'd1234, 32'd4321, 32'd65536);
		send_corner_set();
		run_random(20);
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 5; p++) begin
			cfg_all($urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 64),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 64),
				$urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 32),
				$urandom_range(0, 65535),
				$urandom_range(0, 2) == 0 ? $urandom_range(0, 131071) :
					$urandom_range(16384, 65536));
			run_random(300);
		end
	endtask

	task automatic test_no_idling();
		quiet = 1'b1;
		cfg_all(32'd16, 32'd16, 32'd8, 32'd100, 32'd52429);
		run_random(150);
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		quiet = 1'b0;
		rows_cfg = 11'd16;
		cols_cfg = 11'd16;
		weight_cfg = '0;
		dw_cfg = '0;
		util_cfg = 17'd65536;
		dense_count = '0;
		dw_count = '0;
		mac_sum = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_config_corners();
		test_random_settings();
		test_no_idling();
		repeat (120) @(negedge clk);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("** systolic_gemm_latency_estimator: PASSED **");
		end else begin
			$display("** systolic_gemm_latency_estimator: FAILED **");
		end
		$finish;
	end

endmodule
